FILE: sv/gpa_pkg.sv
// shared types and constants for the gravity pair accumulator
package gpa_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int POS_W           = 32;
    localparam int ACC_W           = 48;
    localparam int D_W             = 58;

    typedef struct packed {
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] target_z;
        logic signed [POS_W-1:0] source_x;
        logic signed [POS_W-1:0] source_y;
        logic signed [POS_W-1:0] source_z;
        logic [POS_W-1:0]        source_mass;
        logic                    first_source;
        logic                    last_source;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][POS_W-1:0]   mag;
        logic [POS_W-1:0]        mass;
        logic [D_W-1:0]          dist_sq;
        logic                    first;
        logic                    last;
    } t_job;

endpackage

FILE: sv/gravity_pair_accumulator.sv
// top level of the softened gravity pair accumulator
// Each input beat carries a target, one source body and first/last marks; a beat
// marked last yields one output beat with the saturated three-axis sum. The front
// end takes one beat per cycle while the queue can accept, through two pipeline
// stages into a job queue of QUEUE_DEPTH entries. The back end works one job at a
// time, taking a new one only when idle, with one shared serial datapath: a job
// with nonzero softened distance runs a square root, a denominator multiply and,
// per axis, a numerator multiply, a divide and a saturating add; a zero-distance job
// runs only the three adds. A job marked last then emits. The back end's serial
// divider sets the sustained rate. softening_sq is written through the cfg port, reset value 1.
module gravity_pair_accumulator
    import gpa_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_softening;
    logic        w_fr_valid;
    logic        w_fr_ready;
    t_job        w_fr_job;
    logic        w_bk_valid;
    logic        w_bk_ready;
    t_job        w_bk_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_softening <= 32'd1;
        end else if (i_cfg_valid) begin
            r_softening <= i_cfg_data;
        end
    end

    gpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .i_softening (r_softening),
        .o_valid     (w_fr_valid),
        .i_ready     (w_fr_ready),
        .o_job       (w_fr_job)
    );

    gpa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_job   (w_fr_job),
        .o_valid (w_bk_valid),
        .i_ready (w_bk_ready),
        .o_job   (w_bk_job)
    );

    gpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bk_valid),
        .o_ready (w_bk_ready),
        .i_job   (w_bk_job),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

FILE: sv/gpa_front.sv
// front end: differences, squares and softened squared distance
module gpa_front
    import gpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    input  logic [31:0] i_softening,
    output logic        o_valid,
    input  logic        i_ready,
    output t_job        o_job
);

    logic                   r_s1_v;
    logic [2:0]             r_s1_neg;
    logic [2:0][POS_W-1:0]  r_s1_mag;
    logic [POS_W-1:0]       r_s1_mass;
    logic                   r_s1_first;
    logic                   r_s1_last;

    logic                   r_s2_v;
    logic [2:0]             r_s2_neg;
    logic [2:0][POS_W-1:0]  r_s2_mag;
    logic [2:0][63:0]       r_s2_sq;
    logic [POS_W-1:0]       r_s2_mass;
    logic                   r_s2_first;
    logic                   r_s2_last;

    logic                   w_s2_ready;
    logic                   w_s1_ready;
    logic [2:0][32:0]       w_diff;
    logic [2:0][32:0]       w_neg_diff;
    logic [65:0]            w_sum;

    assign w_s2_ready = !r_s2_v || i_ready;
    assign w_s1_ready = !r_s1_v || w_s2_ready;
    assign o_ready    = w_s1_ready;

    always_comb begin
        w_diff[0] = {i_data.source_x[31], i_data.source_x}
                  - {i_data.target_x[31], i_data.target_x};
        w_diff[1] = {i_data.source_y[31], i_data.source_y}
                  - {i_data.target_y[31], i_data.target_y};
        w_diff[2] = {i_data.source_z[31], i_data.source_z}
                  - {i_data.target_z[31], i_data.target_z};
        for (int i = 0; i < 3; i++) begin
            w_neg_diff[i] = 33'd0 - w_diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_v <= i_valid;
            end
            if (w_s2_ready) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_neg[i] <= w_diff[i][32];
                r_s1_mag[i] <= w_diff[i][32] ? w_neg_diff[i][31:0] : w_diff[i][31:0];
            end
            r_s1_mass  <= i_data.source_mass;
            r_s1_first <= i_data.first_source;
            r_s1_last  <= i_data.last_source;
        end
        if (w_s2_ready && r_s1_v) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_sq[i] <= 64'(r_s1_mag[i]) * 64'(r_s1_mag[i]);
            end
            r_s2_neg   <= r_s1_neg;
            r_s2_mag   <= r_s1_mag;
            r_s2_mass  <= r_s1_mass;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
        end
    end

    assign w_sum = 66'(r_s2_sq[0] >> FRAC_BITS) + 66'(r_s2_sq[1] >> FRAC_BITS)
                 + 66'(r_s2_sq[2] >> FRAC_BITS) + 66'(i_softening);

    assign o_valid = r_s2_v;

    always_comb begin
        o_job.neg     = r_s2_neg;
        o_job.mag     = r_s2_mag;
        o_job.mass    = r_s2_mass;
        o_job.dist_sq = w_sum[D_W-1:0];
        o_job.first   = r_s2_first;
        o_job.last    = r_s2_last;
    end

endmodule

FILE: sv/gpa_fifo.sv
// short job queue between front and back end
module gpa_fifo
    import gpa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: sv/gpa_back.sv
// back end: serial sqrt, multiply and divide, saturating accumulate
module gpa_back
    import gpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int DW    = 66 - FRAC_BITS;
    localparam int RADW  = DW + FRAC_BITS;
    localparam int RTW   = RADW / 2;
    localparam int DENW  = DW + RTW;
    localparam int NUMW  = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUMW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_MULD = 3'd2;
    localparam logic [2:0] ST_MULN = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [2:0]              r_state;
    logic [1:0]              r_axis;
    logic [CNT_W-1:0]        r_cnt;
    t_job                    r_job;
    logic                    r_zero;
    logic [RADW-1:0]         r_rad;
    logic [RTW:0]            r_rem;
    logic [RTW-1:0]          r_root;
    logic [DENW-1:0]         r_mcand;
    logic [RTW-1:0]          r_mplier;
    logic [DENW-1:0]         r_prod;
    logic [DENW-1:0]         r_den;
    logic [63:0]             r_nmcand;
    logic [31:0]             r_nmplier;
    logic [63:0]             r_nprod;
    logic [NUMW-1:0]         r_num;
    logic [DENW-1:0]         r_drem;
    logic [NUMW-1:0]         r_q;
    logic signed [ACC_W-1:0] r_acc [3];
    logic                    r_sat;
    logic                    r_out_v;
    t_out                    r_out;

    logic [RTW+2:0]          w_rem2;
    logic [RTW+2:0]          w_trial;
    logic                    w_sq_take;
    logic [RTW-1:0]          w_root_nxt;
    logic [DENW-1:0]         w_prod_nxt;
    logic [63:0]             w_nprod_nxt;
    logic [DENW:0]           w_dr;
    logic                    w_div_take;
    logic                    w_qsat;
    logic [ACC_W:0]          w_qmag;
    logic [ACC_W:0]          w_term;
    logic [ACC_W:0]          w_sum;
    logic                    w_hi_clip;
    logic                    w_lo_clip;
    logic [ACC_W-1:0]        w_acc_nxt;
    logic [1:0]              w_axis_nxt;
    logic                    w_emit;

    assign w_rem2     = {r_rem, r_rad[RADW-1 -: 2]};
    assign w_trial    = (RTW+3)'({r_root, 2'b01});
    assign w_sq_take  = w_rem2 >= w_trial;
    assign w_root_nxt = {r_root[RTW-2:0], w_sq_take};

    assign w_prod_nxt  = r_mplier[0] ? r_prod + r_mcand : r_prod;
    assign w_nprod_nxt = r_nmplier[0] ? r_nprod + r_nmcand : r_nprod;

    assign w_dr       = {r_drem, r_num[NUMW-1]};
    assign w_div_take = w_dr >= {1'b0, r_den};

    assign w_qsat     = r_q > NUMW'(ACC_MAX);
    assign w_qmag     = w_qsat ? {1'b0, ACC_MAX} : {1'b0, r_q[ACC_W-1:0]};
    assign w_term     = r_job.neg[r_axis] ? (ACC_W+1)'(0) - w_qmag : w_qmag;
    assign w_sum      = {r_acc[r_axis][ACC_W-1], r_acc[r_axis]} + w_term;
    assign w_hi_clip  = !w_sum[ACC_W] && w_sum[ACC_W-1];
    assign w_lo_clip  = w_sum[ACC_W] && !w_sum[ACC_W-1];
    assign w_acc_nxt  = w_hi_clip ? ACC_MAX : (w_lo_clip ? ACC_MIN : w_sum[ACC_W-1:0]);
    assign w_axis_nxt = r_axis + 1'b1;
    assign w_emit     = (r_state == ST_EMIT) && (!r_out_v || i_ready);

    assign o_ready = r_state == ST_IDLE;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_sat   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_job  <= i_job;
                        r_axis <= '0;
                        r_cnt  <= '0;
                        r_zero <= i_job.dist_sq[DW-1:0] == '0;
                        if (i_job.first) begin
                            r_sat <= 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                r_acc[i] <= '0;
                            end
                        end
                        if (i_job.dist_sq[DW-1:0] == '0) begin
                            r_q     <= '0;
                            r_state <= ST_ADD;
                        end else begin
                            r_rad   <= {i_job.dist_sq[DW-1:0], FRAC_BITS'(0)};
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_state <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= w_sq_take ? (RTW+1)'(w_rem2 - w_trial) : (RTW+1)'(w_rem2);
                    r_root <= w_root_nxt;
                    if (r_cnt == CNT_W'(RTW - 1)) begin
                        r_cnt    <= '0;
                        r_mcand  <= DENW'(r_job.dist_sq[DW-1:0]);
                        r_mplier <= w_root_nxt;
                        r_prod   <= '0;
                        r_state  <= ST_MULD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MULD: begin
                    r_prod   <= w_prod_nxt;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == CNT_W'(RTW - 1)) begin
                        r_cnt     <= '0;
                        r_den     <= w_prod_nxt;
                        r_nmcand  <= 64'(r_job.mass);
                        r_nmplier <= r_job.mag[r_axis];
                        r_nprod   <= '0;
                        r_state   <= ST_MULN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MULN: begin
                    r_nprod   <= w_nprod_nxt;
                    r_nmcand  <= r_nmcand << 1;
                    r_nmplier <= r_nmplier >> 1;
                    if (r_cnt == CNT_W'(31)) begin
                        r_cnt   <= '0;
                        r_num   <= {w_nprod_nxt, FRAC_BITS'(0)};
                        r_drem  <= '0;
                        r_q     <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    r_num  <= r_num << 1;
                    r_drem <= w_div_take ? DENW'(w_dr - {1'b0, r_den}) : DENW'(w_dr);
                    r_q    <= {r_q[NUMW-2:0], w_div_take};
                    if (r_cnt == CNT_W'(NUMW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_ADD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_ADD: begin
                    r_acc[r_axis] <= w_acc_nxt;
                    r_sat         <= r_sat | w_qsat | w_hi_clip | w_lo_clip;
                    r_axis        <= w_axis_nxt;
                    if (r_axis == 2'd2) begin
                        r_state <= r_job.last ? ST_EMIT : ST_IDLE;
                    end else if (r_zero) begin
                        r_state <= ST_ADD;
                    end else begin
                        r_nmcand  <= 64'(r_job.mass);
                        r_nmplier <= r_job.mag[w_axis_nxt];
                        r_nprod   <= '0;
                        r_state   <= ST_MULN;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_out.accel_x   <= r_acc[0];
                        r_out.accel_y   <= r_acc[1];
                        r_out.accel_z   <= r_acc[2];
                        r_out.saturated <= r_sat;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
